FILE: rtl/core/vfc_pkg.sv
// Voxel face culler package: field widths, mode/side/register codes, beat layouts.
// Used by voxel_face_culler_top; no dependencies.
`default_nettype none

package vfc_pkg;

    localparam int MODE_W      = 2;
    localparam int LOC_W       = 4;
    localparam int SIDE_W      = 3;
    localparam int FACE_W      = 6;
    localparam int POS_W       = 21;
    localparam int ORG_W       = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_FACES   = 6;

    localparam int CHUNK_EDGE_DEF = 16;
    localparam int FIFO_DEPTH     = 8;
    localparam int FP_W           = $clog2(FIFO_DEPTH);
    localparam int CRED_W         = $clog2(FIFO_DEPTH + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    localparam logic [MODE_W-1:0] MODE_OWN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NBR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = 2'd2;

    // input tdata layout, lowest bits last
    typedef struct packed {
        logic [FACE_W-1:0] faces_present;
        logic              opaque_bit;
        logic [SIDE_W-1:0] side;
        logic [LOC_W-1:0]  local_z;
        logic [LOC_W-1:0]  local_y;
        logic [LOC_W-1:0]  local_x;
    } t_in_beat;

    // output tdata layout, lowest bits last
    typedef struct packed {
        logic [ORG_W-1:0]  origin_z;
        logic [ORG_W-1:0]  origin_y;
        logic [ORG_W-1:0]  origin_x;
        logic [FACE_W-1:0] visible_faces;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/voxel_face_culler_top.sv
// A query beat passes the input register, RAM read, result register and output FIFO; load beats give no result.
// Throughput: one input beat per cycle; the pipeline never stalls, an 8-entry output
// FIFO absorbs backpressure and tready drops once 8 queries are outstanding.
// Reset (synchronous, active low) clears pipeline valids, FIFO and chunk position;
// the opacity and neighbor plane RAMs are not cleared.
// Depends on vfc_pkg and vfc_ram.
`default_nettype none

module voxel_face_culler_top
    import vfc_pkg::*;
#(
    parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [POS_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // local_x[3:0], local_y[7:4], local_z[11:8], side[14:12], opaque_bit[15],
    // faces_present[21:16], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[1:0]
    input  wire logic [MODE_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // visible_faces[5:0], origin_x[30:6], origin_y[55:31], origin_z[80:56], zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int CUBE_DEPTH  = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int PLANE_DEPTH = CHUNK_EDGE * CHUNK_EDGE;
    localparam int CUBE_AW     = $clog2(CUBE_DEPTH);
    localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
    localparam int KW          = $clog2(CHUNK_EDGE) + LOC_W;

    localparam logic [KW-1:0]        EDGE_K  = KW'(CHUNK_EDGE);
    localparam logic [KW-1:0]        LAST_K  = KW'(CHUNK_EDGE - 1);
    localparam logic [CUBE_AW-1:0]   EDGE_C  = CUBE_AW'(CHUNK_EDGE);
    localparam logic [CUBE_AW-1:0]   PLANE_C = CUBE_AW'(PLANE_DEPTH);
    localparam logic [PLANE_AW-1:0]  EDGE_P  = PLANE_AW'(CHUNK_EDGE);
    localparam logic signed [ORG_W-1:0] EDGE_S = ORG_W'(CHUNK_EDGE);

    // chunk position registers
    logic signed [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POS_X: r_pos_x <= i_cfg_data;
                CFG_POS_Y: r_pos_y <= i_cfg_data;
                CFG_POS_Z: r_pos_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // credit / FIFO control
    logic [CRED_W-1:0] r_cred, n_cred;
    logic [CRED_W-1:0] r_fcnt, n_fcnt;
    logic [FP_W-1:0]   r_wptr, r_rptr;
    t_result           r_fifo [FIFO_DEPTH];
    logic              w_accept, w_is_query, w_pop;

    assign o_s_axis_tready = (r_cred < CRED_W'(FIFO_DEPTH));
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_query = (i_s_axis_tuser == MODE_QUERY);
    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign w_pop      = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_fifo[r_rptr]};

    // stage 1: input register
    logic     r1_v;
    logic [MODE_W-1:0] r1_mode;
    t_in_beat r1_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= w_accept;
        end
        if (w_accept) begin
            r1_mode <= i_s_axis_tuser;
            r1_beat <= t_in_beat'(i_s_axis_tdata[$bits(t_in_beat)-1:0]);
        end
    end

    // stage 1 logic: range, boundary, RAM addresses, products
    logic [KW-1:0]      w_kx, w_ky, w_kz;
    logic               w_xin, w_yin, w_zin, w_allin;
    logic [CUBE_AW-1:0] w_cx, w_cy, w_cz, w_cell;
    logic [PLANE_AW-1:0] w_px, w_py, w_pz;
    logic [NUM_FACES-1:0] w_bnd, w_pl_ok;
    logic [CUBE_AW-1:0]  w_own_raddr [NUM_FACES];
    logic [PLANE_AW-1:0] w_pl_addr [NUM_FACES];
    logic [NUM_FACES-1:0] w_pl_we, w_own_rd, w_pl_rd;
    logic               w_own_we;
    logic signed [ORG_W-1:0] w_sx, w_sy, w_sz;

    always_comb begin
        w_kx  = KW'(r1_beat.local_x);
        w_ky  = KW'(r1_beat.local_y);
        w_kz  = KW'(r1_beat.local_z);
        w_xin = (w_kx < EDGE_K);
        w_yin = (w_ky < EDGE_K);
        w_zin = (w_kz < EDGE_K);
        w_allin = w_xin && w_yin && w_zin;

        w_cx   = CUBE_AW'(r1_beat.local_x);
        w_cy   = CUBE_AW'(r1_beat.local_y);
        w_cz   = CUBE_AW'(r1_beat.local_z);
        w_cell = (w_cz * EDGE_C + w_cy) * EDGE_C + w_cx;

        w_own_raddr[SIDE_LEFT]   = w_cell - CUBE_AW'(1);
        w_own_raddr[SIDE_RIGHT]  = w_cell + CUBE_AW'(1);
        w_own_raddr[SIDE_BOTTOM] = w_cell - EDGE_C;
        w_own_raddr[SIDE_TOP]    = w_cell + EDGE_C;
        w_own_raddr[SIDE_FRONT]  = w_cell - PLANE_C;
        w_own_raddr[SIDE_BACK]   = w_cell + PLANE_C;

        w_px = PLANE_AW'(r1_beat.local_x);
        w_py = PLANE_AW'(r1_beat.local_y);
        w_pz = PLANE_AW'(r1_beat.local_z);
        w_pl_addr[SIDE_LEFT]   = w_pz * EDGE_P + w_py;
        w_pl_addr[SIDE_RIGHT]  = w_pz * EDGE_P + w_py;
        w_pl_addr[SIDE_BOTTOM] = w_pz * EDGE_P + w_px;
        w_pl_addr[SIDE_TOP]    = w_pz * EDGE_P + w_px;
        w_pl_addr[SIDE_FRONT]  = w_py * EDGE_P + w_px;
        w_pl_addr[SIDE_BACK]   = w_py * EDGE_P + w_px;

        w_pl_ok[SIDE_LEFT]   = w_yin && w_zin;
        w_pl_ok[SIDE_RIGHT]  = w_yin && w_zin;
        w_pl_ok[SIDE_BOTTOM] = w_xin && w_zin;
        w_pl_ok[SIDE_TOP]    = w_xin && w_zin;
        w_pl_ok[SIDE_FRONT]  = w_xin && w_yin;
        w_pl_ok[SIDE_BACK]   = w_xin && w_yin;

        w_bnd[SIDE_LEFT]   = (w_kx == '0);
        w_bnd[SIDE_RIGHT]  = (w_kx == LAST_K);
        w_bnd[SIDE_BOTTOM] = (w_ky == '0);
        w_bnd[SIDE_TOP]    = (w_ky == LAST_K);
        w_bnd[SIDE_FRONT]  = (w_kz == '0);
        w_bnd[SIDE_BACK]   = (w_kz == LAST_K);

        w_own_we = r1_v && (r1_mode == MODE_OWN) && w_allin;
        for (int s = 0; s < NUM_FACES; s++) begin
            w_pl_we[s] = r1_v && (r1_mode == MODE_NBR) && w_pl_ok[s]
                         && (r1_beat.side == SIDE_W'(s));
        end

        w_sx = {{(ORG_W - POS_W){r_pos_x[POS_W-1]}}, r_pos_x};
        w_sy = {{(ORG_W - POS_W){r_pos_y[POS_W-1]}}, r_pos_y};
        w_sz = {{(ORG_W - POS_W){r_pos_z[POS_W-1]}}, r_pos_z};
    end

    // opacity stores: six copies of the block bits, one per neighbor read, and one neighbor plane RAM per face
    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        vfc_ram #(
            .DATA_W (1),
            .DEPTH  (CUBE_DEPTH),
            .ADDR_W (CUBE_AW)
        ) u_own (
            .i_clk   (i_clk),
            .i_we    (w_own_we),
            .i_waddr (w_cell),
            .i_wdata (r1_beat.opaque_bit),
            .i_raddr (w_own_raddr[f]),
            .o_rdata (w_own_rd[f])
        );

        vfc_ram #(
            .DATA_W (1),
            .DEPTH  (PLANE_DEPTH),
            .ADDR_W (PLANE_AW)
        ) u_plane (
            .i_clk   (i_clk),
            .i_we    (w_pl_we[f]),
            .i_waddr (w_pl_addr[f]),
            .i_wdata (r1_beat.opaque_bit),
            .i_raddr (w_pl_addr[f]),
            .o_rdata (w_pl_rd[f])
        );
    end

    // stage 2: RAM data arrives, products registered
    logic                    r2_v;
    logic [FACE_W-1:0]       r2_faces;
    logic [NUM_FACES-1:0]    r2_bnd;
    logic [LOC_W-1:0]        r2_x, r2_y, r2_z;
    logic signed [ORG_W-1:0] r2_prod_x, r2_prod_y, r2_prod_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v && (r1_mode == MODE_QUERY);
        end
        r2_faces  <= r1_beat.faces_present & {FACE_W{w_allin}};
        r2_bnd    <= w_bnd;
        r2_x      <= r1_beat.local_x;
        r2_y      <= r1_beat.local_y;
        r2_z      <= r1_beat.local_z;
        r2_prod_x <= w_sx * EDGE_S;
        r2_prod_y <= w_sy * EDGE_S;
        r2_prod_z <= w_sz * EDGE_S;
    end

    // stage 2 logic: hidden test and origin add
    logic [NUM_FACES-1:0] w_hid;
    t_result              w_res;

    always_comb begin
        for (int s = 0; s < NUM_FACES; s++) begin
            w_hid[s] = r2_bnd[s] ? w_pl_rd[s] : w_own_rd[s];
        end
        w_res.visible_faces = r2_faces & ~w_hid;
        w_res.origin_x = r2_prod_x + ORG_W'(r2_x);
        w_res.origin_y = r2_prod_y + ORG_W'(r2_y);
        w_res.origin_z = r2_prod_z + ORG_W'(r2_z);
    end

    // stage 3: result register
    logic    r3_v;
    t_result r3_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_res <= w_res;
    end

    // output FIFO
    always_comb begin
        n_cred = r_cred;
        if (w_accept && w_is_query) begin
            n_cred = n_cred + CRED_W'(1);
        end
        if (w_pop) begin
            n_cred = n_cred - CRED_W'(1);
        end
        n_fcnt = r_fcnt;
        if (r3_v) begin
            n_fcnt = n_fcnt + CRED_W'(1);
        end
        if (w_pop) begin
            n_fcnt = n_fcnt - CRED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
            r_fcnt <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_cred <= n_cred;
            r_fcnt <= n_fcnt;
            if (r3_v) begin
                r_wptr <= r_wptr + FP_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + FP_W'(1);
            end
        end
        if (r3_v) begin
            r_fifo[r_wptr] <= r3_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vfc_ram #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
